// ===== sv/rbp_pkg.sv =====
// Shared types and codes for the record batch v2 byte parser.
// No dependencies; every other file of the block but rbp_ifs refers to this package by scoped names.
package rbp_pkg;

	// Status codes reported on each result item
	localparam logic [3:0] ST_OK            = 4'd0;
	localparam logic [3:0] ST_SHORT_COMMON  = 4'd1;
	localparam logic [3:0] ST_NO_MAGIC      = 4'd2;
	localparam logic [3:0] ST_BAD_MAGIC     = 4'd3;
	localparam logic [3:0] ST_SHORT_HDR     = 4'd4;
	localparam logic [3:0] ST_FIELD_MISSING = 4'd5;
	localparam logic [3:0] ST_NEG_HEADERS   = 4'd6;
	localparam logic [3:0] ST_BAD_LENGTH    = 4'd7;
	localparam logic [3:0] ST_PAST_DATA     = 4'd8;
	localparam logic [3:0] ST_REC_MISMATCH  = 4'd9;
	localparam logic [3:0] ST_LONG_VARINT   = 4'd10;

	// Byte role tags
	localparam logic [1:0] ROLE_FRAME = 2'd0;
	localparam logic [1:0] ROLE_KEY   = 2'd1;
	localparam logic [1:0] ROLE_VALUE = 2'd2;

	// Fixed batch layout
	localparam logic [5:0] COMMON_HDR_BYTES = 6'd16;
	localparam logic [5:0] BATCH_HDR_BYTES  = 6'd44;
	localparam logic [7:0] MAGIC_V2         = 8'd2;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [15:0] topic_id;
		logic [30:0] partition;
	} item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic [1:0]  byte_role;
		logic        record_end;
		logic        batch_end;
		logic [3:0]  parse_status;
		logic [15:0] out_topic_id;
		logic [30:0] out_partition;
	} result_t;

endpackage

// ===== sv/rbp_ifs.sv =====
// Valid/ready channel interfaces for the parser's input and result streams.
// No dependencies.
interface rbp_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic [15:0] topic_id;
	logic [30:0] partition;

	modport source (output valid, output data_byte, output last_byte, output topic_id,
		output partition, input ready);
	modport sink (input valid, input data_byte, input last_byte, input topic_id,
		input partition, output ready);
endinterface

interface rbp_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic [1:0]  byte_role;
	logic        record_end;
	logic        batch_end;
	logic [3:0]  parse_status;
	logic [15:0] out_topic_id;
	logic [30:0] out_partition;

	modport source (output valid, output out_byte, output byte_role, output record_end,
		output batch_end, output parse_status, output out_topic_id, output out_partition,
		input ready);
	modport sink (input valid, input out_byte, input byte_role, input record_end,
		input batch_end, input parse_status, input out_topic_id, input out_partition,
		output ready);
endinterface

// ===== sv/rbp_core.sv =====
// Parser state and per-byte next-state logic: each accepted item advances the parser by one step.
// Depends on rbp_pkg for item/result types and status codes.
module rbp_core #(
	parameter int LENGTH_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  rbp_pkg::item_t   item,
	output rbp_pkg::result_t result
);

	localparam int EW = LENGTH_BITS - 1;
	localparam logic [31:0] LEN_MAX = 32'((64'd1 << (LENGTH_BITS - 1)) - 64'd1);

	localparam logic [4:0] PH_COMMON = 5'd0;
	localparam logic [4:0] PH_MAGIC  = 5'd1;
	localparam logic [4:0] PH_BHDR   = 5'd2;
	localparam logic [4:0] PH_RLEN   = 5'd3;
	localparam logic [4:0] PH_ATTR   = 5'd4;
	localparam logic [4:0] PH_TS     = 5'd5;
	localparam logic [4:0] PH_OFFS   = 5'd6;
	localparam logic [4:0] PH_KLEN   = 5'd7;
	localparam logic [4:0] PH_KDATA  = 5'd8;
	localparam logic [4:0] PH_VLEN   = 5'd9;
	localparam logic [4:0] PH_VDATA  = 5'd10;
	localparam logic [4:0] PH_HCNT   = 5'd11;
	localparam logic [4:0] PH_HKLEN  = 5'd12;
	localparam logic [4:0] PH_HKDATA = 5'd13;
	localparam logic [4:0] PH_HVLEN  = 5'd14;
	localparam logic [4:0] PH_HVDATA = 5'd15;
	localparam logic [4:0] PH_ERROR  = 5'd16;

	logic [4:0]    phase_q, ph_d;
	logic [5:0]    hcnt_q, hcnt_d, hcnt_inc;
	logic [31:0]   acc_q, acc_d, acc_new, part;
	logic [3:0]    vcnt_q, vcnt_d, vcnt_inc, vmax;
	logic [6:0]    vsh;
	logic [31:0]   rec_q, rec_d;
	logic [EW-1:0] elem_q, elem_d, elem_dec;
	logic [30:0]   hdr_q, hdr_d, hdr_dec;
	logic [3:0]    stat_q, stat_d, stat_o;
	logic [31:0]   unz;
	logic          vdone, vover;
	logic          done_go, fin_go;
	logic [4:0]    done_lp;
	logic [1:0]    role;
	logic          rend;

	// Varint byte: place 7 bits at 7*count, decode zigzag of the completed value
	always_comb begin
		vsh      = {vcnt_q, 3'b000} - {3'b000, vcnt_q};
		part     = {25'd0, item.data_byte[6:0]} << vsh;
		acc_new  = acc_q | part;
		vcnt_inc = vcnt_q + 4'd1;
		vmax     = (phase_q == PH_TS) ? 4'd10 : 4'd5;
		vdone    = !item.data_byte[7];
		vover    = item.data_byte[7] && (vcnt_inc >= vmax);
		unz      = (acc_new >> 1) ^ {32{acc_new[0]}};
		hcnt_inc = hcnt_q + 6'd1;
		elem_dec = elem_q - EW'(1);
		hdr_dec  = hdr_q - 31'd1;
	end

	// Next state for one byte
	always_comb begin
		ph_d    = phase_q;
		hcnt_d  = hcnt_q;
		acc_d   = acc_q;
		vcnt_d  = vcnt_q;
		rec_d   = (phase_q >= PH_ATTR && phase_q <= PH_HVDATA) ? rec_q - 32'd1 : rec_q;
		elem_d  = elem_q;
		hdr_d   = hdr_q;
		stat_d  = stat_q;
		role    = rbp_pkg::ROLE_FRAME;
		rend    = 1'b0;
		done_go = 1'b0;
		fin_go  = 1'b0;
		done_lp = phase_q;
		stat_o  = rbp_pkg::ST_OK;

		// shared varint accumulation
		case (phase_q) inside
			PH_RLEN, PH_TS, PH_OFFS, PH_KLEN, PH_VLEN, PH_HCNT, PH_HKLEN, PH_HVLEN: begin
				if (vdone) begin
					acc_d  = '0;
					vcnt_d = '0;
				end else begin
					acc_d  = acc_new;
					vcnt_d = vcnt_inc;
					if (vover) begin
						stat_d = rbp_pkg::ST_LONG_VARINT;
						ph_d   = PH_ERROR;
					end
				end
			end
			default: ;
		endcase

		unique case (phase_q) inside
			PH_COMMON: begin
				if (hcnt_inc >= rbp_pkg::COMMON_HDR_BYTES) begin
					hcnt_d = '0;
					ph_d   = PH_MAGIC;
				end else begin
					hcnt_d = hcnt_inc;
				end
			end
			PH_MAGIC: begin
				if (item.data_byte == rbp_pkg::MAGIC_V2) begin
					hcnt_d = '0;
					ph_d   = PH_BHDR;
				end else begin
					stat_d = rbp_pkg::ST_BAD_MAGIC;
					ph_d   = PH_ERROR;
				end
			end
			PH_BHDR: begin
				if (hcnt_inc >= rbp_pkg::BATCH_HDR_BYTES) begin
					hcnt_d = '0;
					ph_d   = PH_RLEN;
				end else begin
					hcnt_d = hcnt_inc;
				end
			end
			PH_RLEN: begin
				if (vdone) begin
					rec_d = unz;
					ph_d  = PH_ATTR;
				end
			end
			PH_ATTR: ph_d = PH_TS;
			PH_TS: begin
				if (vdone) ph_d = PH_OFFS;
			end
			PH_OFFS: begin
				if (vdone) ph_d = PH_KLEN;
			end
			PH_KLEN, PH_VLEN, PH_HKLEN, PH_HVLEN: begin
				if (vdone) begin
					if (unz == '1 || unz == '0) begin
						done_go = 1'b1;
					end else if (unz[31]) begin
						stat_d = rbp_pkg::ST_BAD_LENGTH;
						ph_d   = PH_ERROR;
					end else if (unz > LEN_MAX) begin
						stat_d = rbp_pkg::ST_PAST_DATA;
						ph_d   = PH_ERROR;
					end else begin
						elem_d = unz[EW-1:0];
						ph_d   = phase_q + 5'd1;
					end
				end
			end
			PH_KDATA, PH_VDATA, PH_HKDATA, PH_HVDATA: begin
				if (phase_q == PH_KDATA) role = rbp_pkg::ROLE_KEY;
				else if (phase_q == PH_VDATA) role = rbp_pkg::ROLE_VALUE;
				elem_d = elem_dec;
				if (elem_dec == '0) begin
					done_go = 1'b1;
					done_lp = phase_q - 5'd1;
				end
			end
			PH_HCNT: begin
				if (vdone) begin
					if (unz[31]) begin
						stat_d = rbp_pkg::ST_NEG_HEADERS;
						ph_d   = PH_ERROR;
					end else if (unz == '0) begin
						fin_go = 1'b1;
					end else begin
						hdr_d = unz[30:0];
						ph_d  = PH_HKLEN;
					end
				end
			end
			default: ;
		endcase

		// element finished: step to the next field, or end the record after its last header
		if (done_go) begin
			unique case (done_lp) inside
				PH_KLEN:  ph_d = PH_VLEN;
				PH_VLEN:  ph_d = PH_HCNT;
				PH_HKLEN: ph_d = PH_HVLEN;
				default: begin
					hdr_d = hdr_dec;
					if (hdr_dec == '0) fin_go = 1'b1;
					else ph_d = PH_HKLEN;
				end
			endcase
		end

		// record finished: byte count must land on zero
		if (fin_go) begin
			if (rec_d != '0) begin
				stat_d = rbp_pkg::ST_REC_MISMATCH;
				ph_d   = PH_ERROR;
			end else begin
				rend = 1'b1;
				ph_d = PH_RLEN;
			end
		end

		if (stat_d != rbp_pkg::ST_OK) begin
			role = rbp_pkg::ROLE_FRAME;
			rend = 1'b0;
		end

		// status for a batch cut off at the last byte
		stat_o = stat_d;
		if (item.last_byte && stat_d == rbp_pkg::ST_OK) begin
			unique case (ph_d) inside
				PH_COMMON: stat_o = rbp_pkg::ST_SHORT_COMMON;
				PH_MAGIC:  stat_o = rbp_pkg::ST_NO_MAGIC;
				PH_BHDR:   stat_o = rbp_pkg::ST_SHORT_HDR;
				PH_RLEN:   stat_o = (vcnt_d != '0) ? rbp_pkg::ST_FIELD_MISSING : rbp_pkg::ST_OK;
				PH_KDATA, PH_VDATA, PH_HKDATA, PH_HVDATA: stat_o = rbp_pkg::ST_PAST_DATA;
				default:   stat_o = rbp_pkg::ST_FIELD_MISSING;
			endcase
		end
	end

	always_comb begin
		result.out_byte      = item.data_byte;
		result.byte_role     = role;
		result.record_end    = rend;
		result.batch_end     = item.last_byte;
		result.parse_status  = stat_o;
		result.out_topic_id  = item.topic_id;
		result.out_partition = item.partition;
	end

	// Parser state; the last byte of a batch returns everything to reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_COMMON;
			hcnt_q  <= '0;
			acc_q   <= '0;
			vcnt_q  <= '0;
			rec_q   <= '0;
			elem_q  <= '0;
			hdr_q   <= '0;
			stat_q  <= rbp_pkg::ST_OK;
		end else if (take) begin
			if (item.last_byte) begin
				phase_q <= PH_COMMON;
				hcnt_q  <= '0;
				acc_q   <= '0;
				vcnt_q  <= '0;
				rec_q   <= '0;
				elem_q  <= '0;
				hdr_q   <= '0;
				stat_q  <= rbp_pkg::ST_OK;
			end else begin
				phase_q <= ph_d;
				hcnt_q  <= hcnt_d;
				acc_q   <= acc_d;
				vcnt_q  <= vcnt_d;
				rec_q   <= rec_d;
				elem_q  <= elem_d;
				hdr_q   <= hdr_d;
				stat_q  <= stat_d;
			end
		end
	end

endmodule

// ===== sv/rbp_out_buf.sv =====
// Two-entry result buffer (output register plus skid register) between parser and sink.
// Depends on rbp_pkg for the result type.
module rbp_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rbp_pkg::result_t push_data,
	output logic             ready,
	output logic             out_valid,
	output rbp_pkg::result_t out_data,
	input  logic             pop
);

	logic             main_valid_q, skid_valid_q;
	rbp_pkg::result_t main_q, skid_q;

	assign ready     = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) skid_valid_q <= 1'b0;
			else main_valid_q <= push;
		end else if (push) begin
			if (main_valid_q) skid_valid_q <= 1'b1;
			else main_valid_q <= 1'b1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) main_q <= skid_q;
			else if (push) main_q <= push_data;
		end else if (push) begin
			if (main_valid_q) skid_q <= push_data;
			else main_q <= push_data;
		end
	end

endmodule

// ===== sv/record_batch_v2_parser.sv =====
// Record batch v2 parser, top level: one result item per input byte.
// A result is registered in the output buffer before it is offered; it waits there while the sink stalls.
// Throughput: one byte per cycle while the buffer's skid register is empty; the parser state updates once per byte.
// A two-entry output buffer keeps input accepted while one result waits at the sink.
// Reset (arst_n low, asynchronous): parser returns to the common header, buffer empties.
// Depends on rbp_pkg, rbp_ifs, rbp_core and rbp_out_buf.
module record_batch_v2_parser #(
	parameter int LENGTH_BITS = 32
) (
	input logic         clk,
	input logic         arst_n,
	rbp_in_if.sink      in_ch,
	rbp_out_if.source   out_ch
);

	rbp_pkg::item_t   item;
	rbp_pkg::result_t res, out_res;
	logic             take, buf_ready;

	assign item.data_byte = in_ch.data_byte;
	assign item.last_byte = in_ch.last_byte;
	assign item.topic_id  = in_ch.topic_id;
	assign item.partition = in_ch.partition;

	assign in_ch.ready = buf_ready;
	assign take        = in_ch.valid && buf_ready;

	rbp_core #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (item),
		.result (res)
	);

	rbp_out_buf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_data (res),
		.ready     (buf_ready),
		.out_valid (out_ch.valid),
		.out_data  (out_res),
		.pop       (out_ch.valid && out_ch.ready)
	);

	assign out_ch.out_byte      = out_res.out_byte;
	assign out_ch.byte_role     = out_res.byte_role;
	assign out_ch.record_end    = out_res.record_end;
	assign out_ch.batch_end     = out_res.batch_end;
	assign out_ch.parse_status  = out_res.parse_status;
	assign out_ch.out_topic_id  = out_res.out_topic_id;
	assign out_ch.out_partition = out_res.out_partition;

endmodule

// ===== sv/rbp_checker.sv =====
// Port-level assertions for the parser's result stream, bound onto the top level.
// Depends on rbp_pkg and record_batch_v2_parser.
module rbp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  out_byte,
	input logic [1:0]  byte_role,
	input logic        record_end,
	input logic        batch_end,
	input logic [3:0]  parse_status
);

	logic       err_open_q;
	logic [3:0] err_code_q;
	logic       out_take;

	assign out_take = out_valid && out_ready;

	// remember an error seen mid-batch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_open_q <= 1'b0;
			err_code_q <= rbp_pkg::ST_OK;
		end else if (out_take) begin
			err_open_q <= (parse_status != rbp_pkg::ST_OK) && !batch_end;
			err_code_q <= parse_status;
		end
	end

	// a completed record never carries an error
	a_rec_end_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_end |-> parse_status == rbp_pkg::ST_OK)
		else $error("record_end with nonzero status");

	// a record ends on a framing byte, never inside key or value payload
	a_rec_end_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_end |-> byte_role == rbp_pkg::ROLE_FRAME)
		else $error("record_end on a payload byte");

	// an error holds until the batch's last item
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && err_open_q |-> parse_status == err_code_q)
		else $error("error status changed before batch end");

	// a stalled result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(parse_status))
		else $error("stalled result changed");

endmodule

bind record_batch_v2_parser rbp_checker u_rbp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.out_byte     (out_ch.out_byte),
	.byte_role    (out_ch.byte_role),
	.record_end   (out_ch.record_end),
	.batch_end    (out_ch.batch_end),
	.parse_status (out_ch.parse_status)
);
